// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
// Implication checked in the cycle after the condition.
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");
`endif

// ===== hdl/llp_pkg.sv =====
// Package with the constants and codes of the predictive parser.
package llp_pkg;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned MAX_EXPANSIONS = 64;
  localparam int unsigned MAX_RHS_LENGTH = 8;
  localparam int unsigned MAX_TERMINALS = 16;

  localparam logic [2:0] MODE_TABLE = 3'd0;
  localparam logic [2:0] MODE_SYM = 3'd1;
  localparam logic [2:0] MODE_LEN = 3'd2;
  localparam logic [2:0] MODE_START = 3'd3;
  localparam logic [2:0] MODE_PARSE = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_SYNTAX = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_LIMIT = 3'd4;

  localparam logic [1:0] ACT_ERROR = 2'd0;
  localparam logic [1:0] ACT_EXPAND = 2'd1;
  localparam logic [1:0] ACT_POP = 2'd2;

  localparam logic CFG_TERMINAL_COUNT = 1'b0;
  localparam logic CFG_START_NT = 1'b1;

  typedef logic [4:0] symbol_t;
endpackage

// ===== hdl/ll1_predictive_parser_unit.sv =====
// LL(1) predictive parser with memory-held table, productions and stack.
// Load and unknown-mode items return a status; a start item pushes the end marker
// and start nonterminal. A parse item reads the stack top and matches a terminal or
// pops or expands a nonterminal from the table, with registered memory reads.
// Sync reset sets state, stack pointer, verdict and config; memories are not cleared.
module ll1_predictive_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: nonterminal[3:0], terminal[7:4], alternative[9:8], position[12:10],
  // symbol[17:13], action[19:18], rhs_length[23:20]
  input  logic [23:0] s_tdata,
  // tuser: mode[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: status[2:0], stack_level[9:3], zero[15:10]
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import llp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_START2 = 3'd1;
  localparam logic [2:0] S_RD_TOP = 3'd2;
  localparam logic [2:0] S_W_TOP = 3'd3;
  localparam logic [2:0] S_W_TBL = 3'd4;
  localparam logic [2:0] S_W_LEN = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;
  localparam logic [2:0] S_FIN = 3'd7;

  // Memories.
  logic [3:0] action_table [256];
  symbol_t    production_symbols [512];
  logic [3:0] production_lengths [64];
  symbol_t    parse_stack [64];

  logic [2:0] state;
  logic [6:0] sp;
  logic [2:0] verdict;
  logic [4:0] terminal_count;
  logic [3:0] start_nt;
  logic [3:0] tok;
  logic [3:0] cur_nt;
  logic [1:0] cur_alt;
  logic [2:0] ridx;
  logic [6:0] steps;
  logic [2:0] res_status;
  logic       is_parse;
  logic [2:0] out_status;
  logic [6:0] out_level;

  logic [3:0] tbl_q;
  symbol_t    sym_q;
  logic [3:0] len_q;
  symbol_t    stk_q;

  logic [3:0] in_nt, in_term, in_len;
  logic [1:0] in_alt, in_act;
  logic [2:0] in_pos;
  symbol_t    in_sym;
  logic       s_acc;
  logic [3:0] endm;

  assign in_nt = s_tdata[3:0];
  assign in_term = s_tdata[7:4];
  assign in_alt = s_tdata[9:8];
  assign in_pos = s_tdata[12:10];
  assign in_sym = s_tdata[17:13];
  assign in_act = s_tdata[19:18];
  assign in_len = s_tdata[23:20];
  assign s_tready = (state == S_IDLE);
  assign s_acc = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata = {6'd0, out_level, out_status};

  // End marker index from the clamped terminal count.
  always_comb begin
    if (terminal_count == 5'd0) begin
      endm = 4'd0;
    end else if (terminal_count > 5'(MAX_TERMINALS)) begin
      endm = 4'(MAX_TERMINALS - 1);
    end else begin
      endm = 4'(terminal_count - 5'd1);
    end
  end

  // Memory port controls.
  logic       stk_we;
  logic [5:0] stk_waddr;
  symbol_t    stk_wdata;
  logic [5:0] stk_raddr;
  logic [2:0] sym_ridx;
  logic [3:0] len_clamped;
  logic [7:0] room;

  assign len_clamped = (len_q > 4'(MAX_RHS_LENGTH)) ? 4'(MAX_RHS_LENGTH) : len_q;
  assign room = 8'(sp) - 8'd1 + 8'(len_clamped);
  assign stk_raddr = 6'(sp - 7'd1);
  assign sym_ridx = (state == S_W_LEN) ? 3'(len_clamped - 4'd1) : 3'(ridx - 3'd1);

  always_comb begin
    stk_we = 1'b0;
    stk_waddr = sp[5:0];
    stk_wdata = sym_q;
    if (s_acc && s_tuser == MODE_START) begin
      stk_we = 1'b1;
      stk_waddr = 6'd0;
      stk_wdata = {1'b0, endm};
    end else if (state == S_START2) begin
      stk_we = 1'b1;
      stk_waddr = 6'd1;
      stk_wdata = {1'b1, start_nt};
    end else if (state == S_PUSH) begin
      stk_we = 1'b1;
    end
  end

  // Action table: written by table loads, read with the top nonterminal.
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == MODE_TABLE) begin
      action_table[{in_nt, in_term}] <= {in_alt, in_act};
    end
    tbl_q <= action_table[{stk_q[3:0], tok}];
  end

  // Production symbols: read in reverse order while pushing.
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == MODE_SYM) begin
      production_symbols[{in_nt, in_alt, in_pos}] <= in_sym;
    end
    sym_q <= production_symbols[{cur_nt, cur_alt, sym_ridx}];
  end

  // Production lengths, stored already clamped.
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == MODE_LEN) begin
      production_lengths[{in_nt, in_alt}] <=
        (in_len > 4'(MAX_RHS_LENGTH)) ? 4'(MAX_RHS_LENGTH) : in_len;
    end
    len_q <= production_lengths[{cur_nt, tbl_q[3:2]}];
  end

  // Parse stack.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      parse_stack[stk_waddr] <= stk_wdata;
    end
    stk_q <= parse_stack[stk_raddr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_count <= 5'd16;
      start_nt <= 4'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TERMINAL_COUNT) begin
        terminal_count <= cfg_data;
      end else begin
        start_nt <= cfg_data[3:0];
      end
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= 7'd0;
      verdict <= ST_OK;
      m_tvalid <= 1'b0;
      is_parse <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            res_status <= ST_OK;
            is_parse <= 1'b0;
            tok <= in_term;
            steps <= 7'd0;
            case (s_tuser)
              MODE_START: begin
                verdict <= ST_OK;
                sp <= 7'd2;
                state <= S_START2;
              end
              MODE_PARSE: begin
                if (verdict != ST_OK) begin
                  res_status <= verdict;
                  state <= S_FIN;
                end else if (in_term > endm) begin
                  res_status <= ST_SYNTAX;
                  is_parse <= 1'b1;
                  state <= S_FIN;
                end else begin
                  is_parse <= 1'b1;
                  state <= S_RD_TOP;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_START2: state <= S_FIN;
        S_RD_TOP: begin
          if (sp == 7'd0) begin
            res_status <= ST_SYNTAX;
            state <= S_FIN;
          end else begin
            state <= S_W_TOP;
          end
        end
        S_W_TOP: begin
          if (!stk_q[4]) begin
            if (stk_q[3:0] != tok) begin
              res_status <= ST_SYNTAX;
            end else if (tok == endm) begin
              res_status <= ST_ACCEPT;
            end else begin
              sp <= sp - 7'd1;
            end
            state <= S_FIN;
          end else begin
            cur_nt <= stk_q[3:0];
            state <= S_W_TBL;
          end
        end
        S_W_TBL: begin
          if (tbl_q[1:0] != ACT_EXPAND && tbl_q[1:0] != ACT_POP) begin
            res_status <= ST_SYNTAX;
            state <= S_FIN;
          end else if (steps == 7'(MAX_EXPANSIONS)) begin
            res_status <= ST_LIMIT;
            state <= S_FIN;
          end else begin
            steps <= steps + 7'd1;
            cur_alt <= tbl_q[3:2];
            if (tbl_q[1:0] == ACT_POP) begin
              sp <= sp - 7'd1;
              state <= S_RD_TOP;
            end else begin
              state <= S_W_LEN;
            end
          end
        end
        S_W_LEN: begin
          if (room > 8'(STACK_DEPTH)) begin
            res_status <= ST_OVERFLOW;
            state <= S_FIN;
          end else begin
            sp <= sp - 7'd1;
            ridx <= 3'(len_clamped - 4'd1);
            state <= (len_clamped == 4'd0) ? S_RD_TOP : S_PUSH;
          end
        end
        S_PUSH: begin
          sp <= sp + 7'd1;
          ridx <= ridx - 3'd1;
          if (ridx == 3'd0) begin
            state <= S_RD_TOP;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_status <= res_status;
            out_level <= sp;
            if (is_parse && res_status != ST_OK) begin
              verdict <= res_status;
            end
            state <= S_IDLE;
          end else begin
            m_tvalid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/llp_checker.sv =====
// Port checker for the predictive parser and its bind.
`include "assert_macros.svh"
module llp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import llp_pkg::*;

  // A pending result stays until it is taken.
  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // Status codes stay within the defined set.
  `CHK_IMPLY(a_status, clk, rst, m_tvalid, m_tdata[2:0] <= ST_LIMIT)
  // The stack level never passes the stack depth.
  `CHK_IMPLY(a_level, clk, rst, m_tvalid, m_tdata[9:3] <= 7'(STACK_DEPTH))
  // An accepted item makes the block busy in the next cycle.
  `CHK_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready)
endmodule

bind ll1_predictive_parser_unit llp_checker u_llp_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
